// ----- design/dcu_pkg.sv -----
package dcu_pkg;

    localparam int S1_LEN = 23;
    localparam int S2_LEN = 16;

    localparam int S1_ROM [0:S1_LEN-1] = '{
        -40863479, 527653260, -61005445, 8974142, -1431548, 236560, -39772, 6747,
        -1150, 197, -34, 6, -1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0
    };

    localparam int S2_ROM [0:S2_LEN-1] = '{
        -21984761, -10930828, 60099, -1387, 62, -4, 0, 0,
        0, 0, 0, 0, 0, 0, 0, 0
    };

    // c[0]/2, truncated toward zero
    localparam logic signed [33:0] S1_C0_HALF = -34'sd20431739;
    localparam logic signed [33:0] S2_C0_HALF = -34'sd10992380;

    localparam logic [29:0] LN2_Q30 = 30'd744261118;

    localparam int DIV_BITS = 47;
    localparam int LOG_BITS = 30;

    typedef struct packed {
        logic [31:0] raw;
        logic [46:0] num;
        logic [31:0] rem;
        logic [46:0] quot;
    } dcu_div_t;

    typedef struct packed {
        logic [4:0]  p;
        logic [30:0] m;
        logic [29:0] frac;
    } dcu_log_t;

    typedef struct packed {
        logic signed [33:0] t;
        logic signed [33:0] d;
        logic signed [33:0] dd;
        logic               big_arg;
    } dcu_cls_t;

    function automatic int dcu_coef(input logic big_arg, input int j, input int order);
        int c;
        c = 0;
        if (j <= order)
        begin
            if (big_arg)
            begin
                if (j < S2_LEN)
                    c = S2_ROM[j];
            end
            else
            begin
                if (j < S1_LEN)
                    c = S1_ROM[j];
            end
        end
        return c;
    endfunction

    // Q30 * Q30 -> Q30, rounded half away from zero
    function automatic logic signed [33:0] dcu_mulq(input logic signed [33:0] a,
                                                    input logic signed [33:0] b);
        logic [33:0] ma;
        logic [33:0] mb;
        logic [67:0] pr;
        logic signed [33:0] r;
        ma = a[33] ? 34'(-a) : 34'(a);
        mb = b[33] ? 34'(-b) : 34'(b);
        pr = ma * mb + (68'd1 << 29);
        r  = $signed(pr[63:30]);
        return (a[33] ^ b[33]) ? -r : r;
    endfunction

endpackage

// ----- design/dcu_if.sv -----
interface dcu_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] x_value;

    modport source (output valid, output x_value, input ready);
    modport sink (input valid, input x_value, output ready);
endinterface

interface dcu_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] psi_value;
    logic               pole_hit;
    logic               saturated;

    modport source (output valid, output psi_value, output pole_hit, output saturated,
                    input ready);
    modport sink (input valid, input psi_value, input pole_hit, input saturated,
                  output ready);
endinterface

// ----- design/dcu_div_cell.sv -----
module dcu_div_cell
    import dcu_pkg::*;
(
    input  logic     clk,
    input  logic     en,
    input  dcu_div_t d,
    output dcu_div_t q
);

    dcu_div_t   q_reg;
    dcu_div_t   q_next;
    logic [32:0] r2;
    logic [32:0] diff;
    logic        ge;

    always_comb
    begin
        r2   = {d.rem, d.num[46]};
        diff = r2 - {1'b0, d.raw};
        ge   = (r2 >= {1'b0, d.raw});
        q_next.raw  = d.raw;
        q_next.num  = {d.num[45:0], 1'b0};
        q_next.rem  = ge ? diff[31:0] : r2[31:0];
        q_next.quot = {d.quot[45:0], ge};
    end

    always_ff @(posedge clk)
    begin
        if (en)
            q_reg <= q_next;
    end

    assign q = q_reg;

endmodule

// ----- design/dcu_log_cell.sv -----
module dcu_log_cell
    import dcu_pkg::*;
(
    input  logic     clk,
    input  logic     en,
    input  dcu_log_t d,
    output dcu_log_t q
);

    dcu_log_t    q_reg;
    dcu_log_t    q_next;
    logic [61:0] sq;
    logic [31:0] s;

    // one fraction bit of log2 per squaring
    always_comb
    begin
        sq = d.m * d.m;
        s  = sq[61:30];
        q_next.p    = d.p;
        q_next.m    = s[31] ? s[31:1] : s[30:0];
        q_next.frac = {d.frac[28:0], s[31]};
    end

    always_ff @(posedge clk)
    begin
        if (en)
            q_reg <= q_next;
    end

    assign q = q_reg;

endmodule

// ----- design/dcu_cls_cell.sv -----
module dcu_cls_cell
    import dcu_pkg::*;
#(
    parameter int C_SMALL = 0,
    parameter int C_LARGE = 0
)
(
    input  logic     clk,
    input  logic     en,
    input  dcu_cls_t d,
    output dcu_cls_t q
);

    dcu_cls_t           q_reg;
    dcu_cls_t           q_next;
    logic signed [33:0] c;
    logic signed [33:0] t2;

    // Clenshaw step: d' = 2t*d - dd + c[j], dd' = d
    always_comb
    begin
        c  = d.big_arg ? 34'(C_LARGE) : 34'(C_SMALL);
        t2 = d.t <<< 1;
        q_next.t       = d.t;
        q_next.big_arg = d.big_arg;
        q_next.d       = dcu_mulq(t2, d.d) - d.dd + c;
        q_next.dd      = d.d;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            q_reg <= q_next;
    end

    assign q = q_reg;

endmodule

// ----- design/digamma_chebyshev_unit_core.sv -----
// Channel  Dir  Payload                          Handshake
// din      in   x_value (Q16.16 unsigned)        valid/ready
// dout     out  psi_value, pole_hit, saturated   valid/ready
//
// One item per cycle while din.ready is high. Each item passes through the
// 47-stage restoring reciprocal chain, then the
// Clenshaw cell row and the final sum and rounding stages.
// rst_n clears only the valid bits. A stalled dout holds one item in the
// output register and one in a skid register; din.ready drops while the skid
// register is full, which freezes the whole chain.
module digamma_chebyshev_unit_core
    import dcu_pkg::*;
#(
    parameter int SMALL_SERIES_ORDER = 7,
    parameter int LARGE_SERIES_ORDER = 7
)
(
    input  logic             clk,
    input  logic             rst_n,
    dcu_in_if.sink           din,
    dcu_out_if.source        dout
);

    localparam int NCLS = (SMALL_SERIES_ORDER > LARGE_SERIES_ORDER) ?
                          SMALL_SERIES_ORDER : LARGE_SERIES_ORDER;
    localparam int LAT  = 52 + NCLS;
    localparam int LN_DLY = 16;

    logic en;
    logic [LAT-1:0] vld_reg;

    // stage 0
    logic [31:0] raw0_reg;

    // reciprocal chain
    dcu_div_t div_in;
    dcu_div_t div_q [0:DIV_BITS-1];

    // log chain
    logic [4:0]  p1_reg;
    logic [4:0]  p1_next;
    logic [31:0] raw1_reg;
    dcu_log_t    log_in_reg;
    dcu_log_t    log_in_next;
    dcu_log_t    log_q [0:LOG_BITS-1];
    logic [4:0]  lsh;
    logic [31:0] lshifted;
    logic [63:0] ln_prod;
    logic [33:0] ln_pipe [0:LN_DLY-1];

    // stage 48
    logic [59:0] prod48_reg;
    logic [46:0] q48_reg;
    logic [31:0] raw48_reg;

    // stage 49
    logic [62:0] vsum;
    logic [32:0] v;
    logic [31:0] x2;
    logic        big_arg;
    logic        small_arg;
    dcu_cls_t    cls_in_reg;
    dcu_cls_t    cls_in_next;
    logic signed [47:0] base_next;
    logic signed [47:0] base_pipe [0:NCLS+1];
    logic               pole_pipe [0:NCLS+2];

    dcu_cls_t cls_q [0:NCLS-1];

    logic signed [33:0] sum_reg;
    logic signed [33:0] sum_next;
    logic signed [48:0] acc_reg;

    // output rounding
    logic [48:0] amag;
    logic [35:0] rmag;
    logic [31:0] res_val;
    logic        res_sat;
    logic        res_pole;

    logic               out_valid_reg;
    logic signed [31:0] out_psi_reg;
    logic               out_pole_reg;
    logic               out_sat_reg;
    logic               skid_valid_reg;
    logic signed [31:0] skid_psi_reg;
    logic               skid_pole_reg;
    logic               skid_sat_reg;

    assign en        = !skid_valid_reg;
    assign din.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[LAT-2:0], din.valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
            raw0_reg <= din.x_value;
    end

    // ---- reciprocal: round(2^46 / raw)
    always_comb
    begin
        div_in.raw  = raw0_reg;
        div_in.num  = (47'd1 << 46) + {16'd0, raw0_reg[31:1]};
        div_in.rem  = '0;
        div_in.quot = '0;
    end

    for (genvar k = 0; k < DIV_BITS; k++)
    begin : g_div
        if (k == 0)
        begin : g_first
            dcu_div_cell u_cell (.clk(clk), .en(en), .d(div_in), .q(div_q[k]));
        end
        else
        begin : g_next
            dcu_div_cell u_cell (.clk(clk), .en(en), .d(div_q[k-1]), .q(div_q[k]));
        end
    end

    // ---- logarithm
    always_comb
    begin
        p1_next = '0;
        for (int i = 0; i < 32; i++)
        begin
            if (raw0_reg[i])
                p1_next = 5'(i);
        end
    end

    always_comb
    begin
        lsh      = 5'd30 - p1_reg;
        lshifted = raw1_reg << lsh;
        log_in_next.p    = p1_reg;
        log_in_next.m    = (p1_reg == 5'd31) ? raw1_reg[31:1] : lshifted[30:0];
        log_in_next.frac = '0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_reg     <= p1_next;
            raw1_reg   <= raw0_reg;
            log_in_reg <= log_in_next;
        end
    end

    for (genvar k = 0; k < LOG_BITS; k++)
    begin : g_log
        if (k == 0)
        begin : g_first
            dcu_log_cell u_cell (.clk(clk), .en(en), .d(log_in_reg), .q(log_q[k]));
        end
        else
        begin : g_next
            dcu_log_cell u_cell (.clk(clk), .en(en), .d(log_q[k-1]), .q(log_q[k]));
        end
    end

    // log2 = (p - 16) + frac; integer part fits 4 bits for arguments >= 2
    assign ln_prod = {4'(log_q[LOG_BITS-1].p - 5'd16), log_q[LOG_BITS-1].frac} * LN2_Q30
                     + (64'd1 << 29);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ln_pipe[0] <= ln_prod[63:30];
            for (int i = 1; i < LN_DLY; i++)
                ln_pipe[i] <= ln_pipe[i-1];
        end
    end

    // ---- stage 48: q squared
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod48_reg <= div_q[DIV_BITS-1].quot[29:0] * div_q[DIV_BITS-1].quot[29:0];
            q48_reg    <= div_q[DIV_BITS-1].quot;
            raw48_reg  <= div_q[DIV_BITS-1].raw;
        end
    end

    // ---- stage 49: series argument and the non-series term
    always_comb
    begin
        big_arg   = |raw48_reg[31:17];
        small_arg = ~|raw48_reg[31:16];
        vsum      = {prod48_reg, 3'b000} + (63'd1 << 29);
        v         = vsum[62:30];
        x2        = {raw48_reg[16:0], 15'd0};
        cls_in_next.d       = '0;
        cls_in_next.dd      = '0;
        cls_in_next.big_arg = big_arg;
        if (big_arg)
        begin
            cls_in_next.t = $signed({1'b0, v}) - 34'sd1073741824;
            base_next     = $signed({14'd0, ln_pipe[LN_DLY-1]})
                            - $signed({2'd0, q48_reg[46:1]});
        end
        else if (small_arg)
        begin
            cls_in_next.t = $signed({2'd0, x2}) - 34'sd1073741824;
            base_next     = -$signed({1'b0, q48_reg});
        end
        else
        begin
            cls_in_next.t = $signed({2'd0, x2}) - 34'sd3221225472;
            base_next     = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cls_in_reg   <= cls_in_next;
            base_pipe[0] <= base_next;
            pole_pipe[0] <= (raw48_reg == 32'd0);
            for (int i = 1; i <= NCLS + 1; i++)
                base_pipe[i] <= base_pipe[i-1];
            for (int i = 1; i <= NCLS + 2; i++)
                pole_pipe[i] <= pole_pipe[i-1];
        end
    end

    // ---- Clenshaw row, coefficient index runs from NCLS down to 1
    for (genvar k = 0; k < NCLS; k++)
    begin : g_cls
        localparam int CS = dcu_coef(1'b0, NCLS - k, SMALL_SERIES_ORDER);
        localparam int CL = dcu_coef(1'b1, NCLS - k, LARGE_SERIES_ORDER);
        if (k == 0)
        begin : g_first
            dcu_cls_cell #(.C_SMALL(CS), .C_LARGE(CL)) u_cell
                (.clk(clk), .en(en), .d(cls_in_reg), .q(cls_q[k]));
        end
        else
        begin : g_next
            dcu_cls_cell #(.C_SMALL(CS), .C_LARGE(CL)) u_cell
                (.clk(clk), .en(en), .d(cls_q[k-1]), .q(cls_q[k]));
        end
    end

    assign sum_next = dcu_mulq(cls_q[NCLS-1].t, cls_q[NCLS-1].d) - cls_q[NCLS-1].dd
                      + (cls_q[NCLS-1].big_arg ? S2_C0_HALF : S1_C0_HALF);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_reg <= sum_next;
            acc_reg <= 49'(base_pipe[NCLS+1]) + 49'(sum_reg);
        end
    end

    // ---- round to Q16.16, half away from zero, then clamp
    always_comb
    begin
        amag     = acc_reg[48] ? 49'(-acc_reg) : 49'(acc_reg);
        rmag     = 36'((amag + 49'd8192) >> 14);
        res_pole = pole_pipe[NCLS+2];
        res_sat  = 1'b0;
        if (res_pole)
        begin
            res_val = 32'h8000_0000;
            res_sat = 1'b1;
        end
        else if (acc_reg[48])
        begin
            if (rmag > 36'h0_8000_0000)
            begin
                res_val = 32'h8000_0000;
                res_sat = 1'b1;
            end
            else
                res_val = 32'(-rmag);
        end
        else
        begin
            if (rmag > 36'h0_7FFF_FFFF)
            begin
                res_val = 32'h7FFF_FFFF;
                res_sat = 1'b1;
            end
            else
                res_val = rmag[31:0];
        end
    end

    // ---- output register with skid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || dout.ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
                out_valid_reg <= en && vld_reg[LAT-1];
        end
        else if (en && vld_reg[LAT-1])
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || dout.ready)
        begin
            if (skid_valid_reg)
            begin
                out_psi_reg  <= skid_psi_reg;
                out_pole_reg <= skid_pole_reg;
                out_sat_reg  <= skid_sat_reg;
            end
            else
            begin
                out_psi_reg  <= $signed(res_val);
                out_pole_reg <= res_pole;
                out_sat_reg  <= res_sat;
            end
        end
        else if (en && vld_reg[LAT-1])
        begin
            skid_psi_reg  <= $signed(res_val);
            skid_pole_reg <= res_pole;
            skid_sat_reg  <= res_sat;
        end
    end

    assign dout.valid     = out_valid_reg;
    assign dout.psi_value = out_psi_reg;
    assign dout.pole_hit  = out_pole_reg;
    assign dout.saturated = out_sat_reg;

endmodule
